[design/fpmr_pkg.sv]
// Package for the feedback presence monitor reporter.
// Holds channel count, register indexes, reset values and frame characters.
// No dependencies.
package fpmr_pkg;

  localparam int CHANNELS = 8;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD = 1'd1;

  localparam logic [7:0] WINDOW_RESET    = 8'd200;
  localparam logic [7:0] THRESHOLD_RESET = 8'd20;
  localparam logic [7:0] COUNT_MAX       = 8'hFF;

  localparam logic [7:0] ASCII_HASH   = 8'h23;
  localparam logic [7:0] ASCII_ONE    = 8'h31;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [7:0] ASCII_AT     = 8'h40;
  localparam logic [7:0] ASCII_DIGIT0 = 8'h30;
  localparam logic [7:0] ASCII_DOLLAR = 8'h24;

  localparam logic [2:0] POS_HASH   = 3'd0;
  localparam logic [2:0] POS_STATUS = 3'd1;
  localparam logic [2:0] POS_AT     = 3'd2;
  localparam logic [2:0] POS_CHAN   = 3'd3;
  localparam logic [2:0] POS_LAST   = 3'd4;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_POLL   = 1'b1;

endpackage

[design/feedback_presence_monitor_reporter.sv]
// Feedback presence monitor reporter: counts low samples on the feedback
// lines, judges each line on or off per window, and reports changes as
// five-byte ASCII frames. Depends on fpmr_pkg.
//
// The block takes one item per clock. A poll that finds a set change flag
// loads the output register with '#', valid the cycle after the poll is
// taken, and the frame drains one byte per cycle in which out_stall is low, while
// items keep arriving. The input stalls, for every kind of item, only once
// tx_complete has returned the block to checking while bytes of the last
// frame still wait at the output; it holds until the closing byte is taken.
// Configuration writes are always ready.
module feedback_presence_monitor_reporter
  import fpmr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 kind,
  input  logic [7:0]           feedback_pins,
  input  logic                 tx_complete,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           frame_byte,
  output logic                 last_byte,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic [7:0]          window_length;
  logic [7:0]          low_threshold;
  logic [7:0]          window_count;
  logic [7:0]          low_counts [CHANNELS];
  logic [CHANNELS-1:0] line_status;
  logic [CHANNELS-1:0] change_flags;
  logic [2:0]          scan_index;
  logic                waiting_for_tx;
  logic [2:0]          byte_pos;
  logic                frame_on;
  logic [2:0]          frame_ch;

  logic       in_fire;
  logic       out_fire;
  logic       sample_fire;
  logic       poll_fire;
  logic       eval_now;
  logic [2:0] cur_ch;
  logic [2:0] scan_index_next;
  logic       send_frame;
  logic [2:0] byte_pos_next;

  function automatic logic [7:0] byte_at(input logic [2:0] pos, input logic on,
                                         input logic [2:0] ch);
    logic [7:0] b;
    case (pos)
      POS_HASH:   b = ASCII_HASH;
      POS_STATUS: b = on ? ASCII_ONE : ASCII_ZERO;
      POS_AT:     b = ASCII_AT;
      POS_CHAN:   b = ASCII_DIGIT0 + {5'd0, ch};
      POS_LAST:   b = ASCII_DOLLAR;
      default:    b = ASCII_DOLLAR;
    endcase
    return b;
  endfunction

  assign cfg_ready   = 1'b1;
  assign in_stall    = out_valid && !waiting_for_tx;
  assign in_fire     = in_valid && !in_stall;
  assign out_fire    = out_valid && !out_stall;
  assign sample_fire = in_fire && (kind == KIND_SAMPLE);
  assign poll_fire   = in_fire && (kind == KIND_POLL);
  assign eval_now    = window_count == 8'd0;

  always_comb begin
    cur_ch = (32'(scan_index) >= CHANNELS) ? 3'd0 : scan_index;
    scan_index_next = (32'(cur_ch) + 1 >= CHANNELS) ? 3'd0 : cur_ch + 3'd1;
    send_frame = poll_fire && !waiting_for_tx && change_flags[cur_ch];
    byte_pos_next = byte_pos + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
      low_threshold <= THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: window_length <= cfg_data;
        REG_LOW_THRESHOLD: low_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= WINDOW_RESET;
      line_status  <= '0;
      change_flags <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        low_counts[i] <= 8'd0;
      end
    end else begin
      if (sample_fire) begin
        if (eval_now) begin
          window_count <= window_length;
          for (int i = 0; i < CHANNELS; i++) begin
            low_counts[i] <= 8'd0;
            if ((low_counts[i] < low_threshold) != line_status[i]) begin
              line_status[i]  <= low_counts[i] < low_threshold;
              change_flags[i] <= 1'b1;
            end
          end
        end else begin
          window_count <= window_count - 8'd1;
          for (int i = 0; i < CHANNELS; i++) begin
            if (!feedback_pins[i] && low_counts[i] != COUNT_MAX) begin
              low_counts[i] <= low_counts[i] + 8'd1;
            end
          end
        end
      end
      if (poll_fire && !waiting_for_tx) begin
        change_flags[cur_ch] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_index     <= 3'd0;
      waiting_for_tx <= 1'b0;
    end else if (poll_fire) begin
      if (waiting_for_tx) begin
        if (tx_complete) begin
          waiting_for_tx <= 1'b0;
        end
      end else begin
        scan_index <= scan_index_next;
        if (change_flags[cur_ch]) begin
          waiting_for_tx <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      byte_pos  <= POS_HASH;
    end else if (send_frame) begin
      out_valid <= 1'b1;
      byte_pos  <= POS_HASH;
    end else if (out_fire) begin
      if (byte_pos == POS_LAST) begin
        out_valid <= 1'b0;
      end else begin
        byte_pos <= byte_pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (send_frame) begin
      frame_on   <= line_status[cur_ch];
      frame_ch   <= cur_ch;
      frame_byte <= ASCII_HASH;
      last_byte  <= 1'b0;
    end else if (out_fire && byte_pos != POS_LAST) begin
      frame_byte <= byte_at(byte_pos_next, frame_on, frame_ch);
      last_byte  <= byte_pos_next == POS_LAST;
    end
  end

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (out_fire && last_byte) |=> !out_valid)
    else $error("output still valid after closing byte");

  a_frame_opens_hash: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (frame_byte == ASCII_HASH && waiting_for_tx))
    else $error("frame did not open with hash while waiting");

  a_last_is_dollar: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_byte) |-> (frame_byte == ASCII_DOLLAR && byte_pos == POS_LAST))
    else $error("closing byte mismatch");

  a_no_frame_overlap: assert property (@(posedge clk) disable iff (rst)
    send_frame |-> !out_valid)
    else $error("new frame while previous still draining");

endmodule
